>>> src/pic_pkg.sv
// Shared types and constants for the priority interrupt controller.
// Holds the register map, operation codes and the store control struct.
// No dependencies.
package pic_pkg;

   localparam int LINE_COUNT_DEF = 128;

   localparam logic [1:0] OP_READ  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_EVENT = 2'd2;

   localparam logic [31:0] ID_WORD  = 32'h0031_C011;
   localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

   localparam logic [11:0] OFS_ID      = 12'h000;
   localparam logic [11:0] OFS_FIQ_ACK = 12'h008;
   localparam logic [11:0] OFS_IRQ_ACK = 12'h014;
   localparam logic [11:0] OFS_FIQ_NUM = 12'h018;
   localparam logic [11:0] OFS_IRQ_NUM = 12'h01C;
   localparam logic [11:0] OFS_TABLE   = 12'h030;

   // Write strobes and pending-bit write data for the line store
   typedef struct packed {
      logic prio_we;
      logic pend_we;
      logic pend_wdata;
   } store_ctl_type;

endpackage

>>> src/priority_interrupt_controller.sv
// Channel    | Ports                                             | Beat taken when
// -----------+---------------------------------------------------+------------------
// request    | req_operation/address/write_data/line_number/level | start && !busy
// response   | rsp_read_data, rsp_irq_out, rsp_bad_line          | rsp_valid (1 cycle)
//
// Register reads, writes and line events that start no search answer in the cycle
// after the beat; table reads and raises of an already pending line first pass
// through a wait state for the registered store read. A line latch or an
// acknowledge with a winner runs a winner scan over the line store, one entry
// read per cycle through the single memory read port, and answers when the scan ends.
// busy is high from the beat up to the answer of every multi-cycle item.
// Synchronous reset clears all pending bits and priorities through valid bits,
// with no clearing pass. The response cannot be stalled.
// Depends on pic_pkg and pic_store.
module priority_interrupt_controller #(
   parameter int LINE_COUNT = pic_pkg::LINE_COUNT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_operation,
   input  logic [11:0] req_address,
   input  logic [31:0] req_write_data,
   input  logic [7:0]  req_line_number,
   input  logic        req_line_level,
   output logic        rsp_valid,
   output logic [31:0] rsp_read_data,
   output logic        rsp_irq_out,
   output logic        rsp_bad_line
);
   import pic_pkg::*;

   localparam int IDX_W = $clog2(LINE_COUNT);
   localparam int CNT_W = $clog2(LINE_COUNT + 1);
   localparam logic [12:0] TABLE_END = 13'(32'(OFS_TABLE) + 4 * LINE_COUNT);

   typedef enum logic [1:0] {ST_IDLE, ST_RD_WAIT, ST_EV_WAIT, ST_SCAN} state_type;

   state_type        state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             scan_vld_ff, scan_vld_in;
   logic [IDX_W-1:0] scan_idx_ff, scan_idx_in;
   logic             found_ff, found_in;
   logic [31:0]      best_prio_ff, best_prio_in;
   logic [IDX_W-1:0] best_idx_ff, best_idx_in;
   logic             win_vld_ff, win_vld_in;
   logic [IDX_W-1:0] win_idx_ff, win_idx_in;
   logic [IDX_W-1:0] line_ff, line_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic [31:0]      rsp_data_ff, rsp_data_in;
   logic             rsp_irq_ff, rsp_irq_in;
   logic             rsp_bad_ff, rsp_bad_in;

   store_ctl_type    ctl;
   logic [IDX_W-1:0] wr_idx;
   logic [31:0]      prio_wdata;
   logic [IDX_W-1:0] rd_idx;
   logic [31:0]      prio_rdata;
   logic             pend_rdata;

   logic             accept;
   logic             in_table;
   logic [11:0]      addr_off;
   logic [IDX_W-1:0] table_idx;
   logic             line_ok;
   logic [31:0]      reg_rdata;
   logic             better;

   pic_store #(
      .LINE_COUNT (LINE_COUNT),
      .IDX_W      (IDX_W)
   ) u_store (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .wr_idx     (wr_idx),
      .prio_wdata (prio_wdata),
      .rd_idx     (rd_idx),
      .prio_rdata (prio_rdata),
      .pend_rdata (pend_rdata)
   );

   assign accept    = start && (state_ff == ST_IDLE);
   assign addr_off  = req_address - OFS_TABLE;
   assign table_idx = addr_off[IDX_W+1:2];
   assign in_table  = (req_address >= OFS_TABLE) && ({1'b0, req_address} < TABLE_END);
   assign line_ok   = {1'b0, req_line_number} < 9'(LINE_COUNT);

   always_comb begin
      unique case (req_address) inside
         OFS_ID:                               reg_rdata = ID_WORD;
         OFS_FIQ_ACK, OFS_IRQ_ACK, OFS_FIQ_NUM: reg_rdata = '0;
         OFS_IRQ_NUM:                          reg_rdata = win_vld_ff ? 32'(win_idx_ff) : '0;
         default:                              reg_rdata = ALL_ONES;
      endcase
   end

   // Enabled, pending and strictly smaller than the best so far
   assign better = pend_rdata && (prio_rdata != '0) && (!found_ff || prio_rdata < best_prio_ff);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      scan_vld_in  = 1'b0;
      scan_idx_in  = scan_idx_ff;
      found_in     = found_ff;
      best_prio_in = best_prio_ff;
      best_idx_in  = best_idx_ff;
      win_vld_in   = win_vld_ff;
      win_idx_in   = win_idx_ff;
      line_in      = line_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      rsp_irq_in   = win_vld_ff;
      rsp_bad_in   = 1'b0;
      ctl          = '0;
      wr_idx       = table_idx;
      prio_wdata   = req_write_data;
      rd_idx       = (req_operation == OP_READ) ? table_idx : req_line_number[IDX_W-1:0];

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               line_in = req_line_number[IDX_W-1:0];
               unique case (req_operation)
                  OP_READ: begin
                     if (in_table) begin
                        state_in = ST_RD_WAIT;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_data_in  = reg_rdata;
                     end
                  end
                  OP_WRITE: begin
                     if (req_address == OFS_IRQ_ACK && win_vld_ff) begin
                        // drop the winner's pending bit and search again
                        ctl.pend_we = 1'b1;
                        wr_idx      = win_idx_ff;
                        cnt_in      = '0;
                        found_in    = 1'b0;
                        state_in    = ST_SCAN;
                     end else begin
                        ctl.prio_we  = in_table;
                        rsp_valid_in = 1'b1;
                     end
                  end
                  OP_EVENT: begin
                     if (line_ok && req_line_level) begin
                        state_in = ST_EV_WAIT;
                     end else begin
                        rsp_valid_in = 1'b1;
                        rsp_bad_in   = !line_ok;
                     end
                  end
                  default: begin
                     rsp_valid_in = 1'b1;
                  end
               endcase
            end
         end
         ST_RD_WAIT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = prio_rdata;
            state_in     = ST_IDLE;
         end
         ST_EV_WAIT: begin
            if (pend_rdata) begin
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end else begin
               ctl.pend_we    = 1'b1;
               ctl.pend_wdata = 1'b1;
               wr_idx         = line_ff;
               cnt_in         = '0;
               found_in       = 1'b0;
               state_in       = ST_SCAN;
            end
         end
         ST_SCAN: begin
            rd_idx = cnt_ff[IDX_W-1:0];
            if (cnt_ff < CNT_W'(LINE_COUNT)) begin
               scan_vld_in = 1'b1;
               scan_idx_in = cnt_ff[IDX_W-1:0];
               cnt_in      = cnt_ff + 1'b1;
            end
            if (scan_vld_ff && better) begin
               found_in     = 1'b1;
               best_prio_in = prio_rdata;
               best_idx_in  = scan_idx_ff;
            end
            if (cnt_ff == CNT_W'(LINE_COUNT) && !scan_vld_ff) begin
               win_vld_in   = found_ff;
               win_idx_in   = found_ff ? best_idx_ff : '0;
               rsp_valid_in = 1'b1;
               rsp_irq_in   = found_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         scan_vld_ff  <= 1'b0;
         found_ff     <= 1'b0;
         win_vld_ff   <= 1'b0;
         win_idx_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         scan_vld_ff  <= scan_vld_in;
         found_ff     <= found_in;
         win_vld_ff   <= win_vld_in;
         win_idx_ff   <= win_idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      scan_idx_ff  <= scan_idx_in;
      best_prio_ff <= best_prio_in;
      best_idx_ff  <= best_idx_in;
      line_ff      <= line_in;
      rsp_data_ff  <= rsp_data_in;
      rsp_irq_ff   <= rsp_irq_in;
      rsp_bad_ff   <= rsp_bad_in;
   end

   assign busy          = (state_ff != ST_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;
   assign rsp_irq_out   = rsp_irq_ff;
   assign rsp_bad_line  = rsp_bad_ff;

endmodule

>>> src/pic_store.sv
// Line store: priority words and pending bits in two synchronous memories.
// One write and one read port each, read data registered; per-entry valid
// bits make never-written entries read as zero. Depends on pic_pkg.
module pic_store #(
   parameter int LINE_COUNT = pic_pkg::LINE_COUNT_DEF,
   parameter int IDX_W      = $clog2(LINE_COUNT)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pic_pkg::store_ctl_type ctl,
   input  logic [IDX_W-1:0]      wr_idx,
   input  logic [31:0]           prio_wdata,
   input  logic [IDX_W-1:0]      rd_idx,
   output logic [31:0]           prio_rdata,
   output logic                  pend_rdata
);
   import pic_pkg::*;

   logic [31:0]           prio_mem [LINE_COUNT];
   logic                  pend_mem [LINE_COUNT];
   logic [LINE_COUNT-1:0] prio_vld_ff;
   logic [LINE_COUNT-1:0] pend_vld_ff;
   logic [31:0]           prio_q_ff;
   logic                  pend_q_ff;
   logic                  prio_qv_ff;
   logic                  pend_qv_ff;

   always_ff @(posedge clock) begin
      if (ctl.prio_we) begin
         prio_mem[wr_idx] <= prio_wdata;
      end
      if (ctl.pend_we) begin
         pend_mem[wr_idx] <= ctl.pend_wdata;
      end
      prio_q_ff <= prio_mem[rd_idx];
      pend_q_ff <= pend_mem[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prio_vld_ff <= '0;
         pend_vld_ff <= '0;
         prio_qv_ff  <= 1'b0;
         pend_qv_ff  <= 1'b0;
      end else begin
         if (ctl.prio_we) begin
            prio_vld_ff[wr_idx] <= 1'b1;
         end
         if (ctl.pend_we) begin
            pend_vld_ff[wr_idx] <= 1'b1;
         end
         prio_qv_ff <= prio_vld_ff[rd_idx];
         pend_qv_ff <= pend_vld_ff[rd_idx];
      end
   end

   assign prio_rdata = prio_qv_ff ? prio_q_ff : '0;
   assign pend_rdata = pend_qv_ff & pend_q_ff;

endmodule

>>> src/pic_checker.sv
// Port-level checks for the priority interrupt controller, bound to the top.
// Watches the request handshake and the response strobe. Depends on pic_pkg.
module pic_checker #(
   parameter int LINE_COUNT = pic_pkg::LINE_COUNT_DEF
) (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic [1:0]  req_operation,
   input logic [11:0] req_address,
   input logic [7:0]  req_line_number,
   input logic        rsp_valid,
   input logic [31:0] rsp_read_data,
   input logic        rsp_bad_line
);
   import pic_pkg::*;

   logic beat;
   assign beat = start && !busy;

   // every accepted beat either answers next cycle or starts work
   a_beat_progress: assert property (@(posedge clock) disable iff (reset)
      beat |=> (rsp_valid || busy))
      else $error("accepted beat neither answered nor started work");

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("response while still busy");

   a_bad_line: assert property (@(posedge clock) disable iff (reset)
      beat && req_operation == OP_EVENT && {1'b0, req_line_number} >= 9'(LINE_COUNT)
      |=> rsp_valid && rsp_bad_line && rsp_read_data == '0)
      else $error("out-of-range line not flagged");

   a_id_read: assert property (@(posedge clock) disable iff (reset)
      beat && req_operation == OP_READ && req_address == OFS_ID
      |=> rsp_valid && rsp_read_data == ID_WORD && !rsp_bad_line)
      else $error("wrong ID word");

   a_reset: assert property (@(posedge clock)
      reset |=> !busy && !rsp_valid)
      else $error("not idle after reset");

endmodule

bind priority_interrupt_controller pic_checker #(.LINE_COUNT(LINE_COUNT)) u_pic_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .req_operation   (req_operation),
   .req_address     (req_address),
   .req_line_number (req_line_number),
   .rsp_valid       (rsp_valid),
   .rsp_read_data   (rsp_read_data),
   .rsp_bad_line    (rsp_bad_line)
);
